@@ hw/rtl/bfs_pkg.sv @@
// shared types, constants and helpers of the bone-limited face splitter
package bfs_pkg;

  // default sizes handed to the top level
  localparam int BONE_SPACE_DEF = 256;
  localparam int MAX_FACES_DEF  = 65536;

  // face queue between front and back
  localparam int Q_DEPTH = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BONES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_MINUS1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC_MESH  = 2'd2;
  localparam int CFG_DATA_W = 9;

  localparam logic [8:0] MAX_BONES_RST = 9'd256;

  // result status codes
  localparam logic [1:0] ST_SPLIT    = 2'd0;
  localparam logic [1:0] ST_OVER_CAP = 2'd1;
  localparam logic [1:0] ST_BAD_BONE = 2'd2;

  typedef struct packed {
    logic [8:0] max_bones;
    logic       unused_is_minus_one;
    logic       dynamic_mesh;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] bone_index;
    logic              weight_zero;
    logic              last_of_face;
    logic              last_face;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] first_face;
    logic [16:0] past_face;
    logic [1:0]  word_index;
    logic [63:0] bone_mask_word;
    logic [8:0]  bone_count;
    logic        last_of_split;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_COUNT,
    BK_DECIDE,
    BK_EMIT
  } back_state_t;

  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/bfs_front.sv @@
// front end: classifies bone slots and gathers each face's bone mask
module bfs_front #(
  parameter int BONE_SPACE = bfs_pkg::BONE_SPACE_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  bfs_pkg::cfg_t                              cfg,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  bfs_pkg::in_item_t                          in_data,
  input  logic                                       q_full,
  output logic                                       q_push,
  output logic [((BONE_SPACE+63)/64)*64+1:0]         q_wdata
);
  import bfs_pkg::*;

  localparam int MW = ((BONE_SPACE + 63) / 64) * 64;

  logic [MW-1:0] acc_r, acc_nxt;
  logic          bad_r, bad_nxt;
  logic          accept;
  logic          is_minus_one;
  logic          unused;
  logic          out_of_range;
  logic [MW-1:0] slot_bit;
  logic [MW-1:0] face_mask;
  logic          face_bad;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_minus_one = (in_data.bone_index == -9'sd1);

  always_comb begin
    if (cfg.unused_is_minus_one) begin
      unused = is_minus_one;
    end else if (cfg.dynamic_mesh) begin
      unused = in_data.weight_zero;
    end else begin
      unused = 1'b0;
    end
  end

  // negative bones and bones past the bone space are not real bones
  assign out_of_range = in_data.bone_index[8] ||
                        (32'(in_data.bone_index[7:0]) >= 32'(BONE_SPACE));

  assign slot_bit  = (!unused && !out_of_range) ?
                     (MW'(1) << in_data.bone_index[7:0]) : '0;
  assign face_mask = acc_r | slot_bit;
  assign face_bad  = bad_r || (!unused && out_of_range);

  assign q_push  = accept && in_data.last_of_face;
  assign q_wdata = {in_data.last_face, face_bad, face_mask};

  always_comb begin
    acc_nxt = acc_r;
    bad_nxt = bad_r;
    if (accept) begin
      if (in_data.last_of_face) begin
        acc_nxt = '0;
        bad_nxt = 1'b0;
      end else begin
        acc_nxt = face_mask;
        bad_nxt = face_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      bad_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      bad_r <= bad_nxt;
    end
  end

endmodule

@@ hw/rtl/bfs_queue.sv @@
// short queue of finished faces between front and back
module bfs_queue #(
  parameter int W = 258
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);
  import bfs_pkg::*;

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(Q_DEPTH - 1);
  localparam logic [NW-1:0] CNT_FULL = NW'(Q_DEPTH);

  logic [W-1:0]  mem_r [Q_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

@@ hw/rtl/bfs_back.sv @@
// back end: merges faces into the open split and reports closed splits and dropped faces
module bfs_back #(
  parameter int BONE_SPACE = bfs_pkg::BONE_SPACE_DEF,
  parameter int MAX_FACES  = bfs_pkg::MAX_FACES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bfs_pkg::cfg_t                       cfg,
  input  logic                                q_valid,
  input  logic [((BONE_SPACE+63)/64)*64+1:0]  q_rdata,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bfs_pkg::out_item_t                  out_data
);
  import bfs_pkg::*;

  localparam int BW  = (BONE_SPACE + 63) / 64;
  localparam int MW  = BW * 64;
  localparam int CW  = $clog2(BONE_SPACE + 1);
  localparam int KW  = (CW > 9) ? CW : 9;
  localparam int FCW = $clog2(MAX_FACES + 1);
  localparam int WW  = (BW > 1) ? $clog2(BW) : 1;
  localparam logic [FCW-1:0] CTR_MAX   = FCW'(MAX_FACES);
  localparam logic [WW-1:0]  WORD_LAST = WW'(BW - 1);

  back_state_t state_r, state_nxt;

  // face under work
  logic [BW-1:0][63:0] face_r, face_nxt;
  logic                bad_r, bad_nxt;
  logic                last_r, last_nxt;
  logic [BW-1:0][6:0]  fcw_r, fcw_nxt;
  logic [BW-1:0][6:0]  mcw_r, mcw_nxt;

  // open split
  logic [BW-1:0][63:0] run_r, run_nxt;
  logic [CW-1:0]       run_cnt_r, run_cnt_nxt;
  logic [FCW-1:0]      start_r, start_nxt;
  logic [FCW-1:0]      ctr_r, ctr_nxt;

  // split being reported
  logic [BW-1:0][63:0] emit_mask_r, emit_mask_nxt;
  logic [FCW-1:0]      emit_start_r, emit_start_nxt;
  logic [FCW-1:0]      emit_end_r, emit_end_nxt;
  logic [CW-1:0]       emit_cnt_r, emit_cnt_nxt;
  logic [WW-1:0]       word_r, word_nxt;
  logic                final_pend_r, final_pend_nxt;

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r;
  out_item_t           out_item;
  logic                out_load;

  logic [CW-1:0]       fcount;
  logic [CW-1:0]       mcount;
  logic [FCW-1:0]      ctr_inc;
  logic                ld_ok;
  logic                face_err;
  logic                over_merge;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign ld_ok     = !out_valid_r || out_ready;

  always_comb begin
    fcount = '0;
    mcount = '0;
    for (int w = 0; w < BW; w++) begin
      fcount = fcount + CW'(fcw_r[w]);
      mcount = mcount + CW'(mcw_r[w]);
    end
  end

  assign ctr_inc    = (ctr_r == CTR_MAX) ? ctr_r : ctr_r + 1'b1;
  assign face_err   = bad_r || (KW'(fcount) > KW'(cfg.max_bones));
  assign over_merge = (KW'(mcount) > KW'(cfg.max_bones));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = BK_COUNT;
        end
      end
      BK_COUNT: begin
        state_nxt = BK_DECIDE;
      end
      BK_DECIDE: begin
        if (face_err) begin
          if (ld_ok) begin
            state_nxt = last_r ? BK_EMIT : BK_IDLE;
          end
        end else if (over_merge) begin
          state_nxt = BK_EMIT;
        end else begin
          state_nxt = last_r ? BK_EMIT : BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (ld_ok && (word_r == WORD_LAST) && !final_pend_r) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop          = 1'b0;
    out_load       = 1'b0;
    out_item       = '0;
    face_nxt       = face_r;
    bad_nxt        = bad_r;
    last_nxt       = last_r;
    fcw_nxt        = fcw_r;
    mcw_nxt        = mcw_r;
    run_nxt        = run_r;
    run_cnt_nxt    = run_cnt_r;
    start_nxt      = start_r;
    ctr_nxt        = ctr_r;
    emit_mask_nxt  = emit_mask_r;
    emit_start_nxt = emit_start_r;
    emit_end_nxt   = emit_end_r;
    emit_cnt_nxt   = emit_cnt_r;
    word_nxt       = word_r;
    final_pend_nxt = final_pend_r;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          face_nxt = q_rdata[MW-1:0];
          bad_nxt  = q_rdata[MW];
          last_nxt = q_rdata[MW+1];
        end
      end
      BK_COUNT: begin
        for (int w = 0; w < BW; w++) begin
          fcw_nxt[w] = popcount64(face_r[w]);
          mcw_nxt[w] = popcount64(run_r[w] | face_r[w]);
        end
      end
      BK_DECIDE: begin
        word_nxt       = '0;
        final_pend_nxt = 1'b0;
        if (face_err) begin
          // dropped face: one error result, open split kept unless it is the last face
          if (ld_ok) begin
            out_load                = 1'b1;
            out_item.status         = bad_r ? ST_BAD_BONE : ST_OVER_CAP;
            out_item.first_face     = 16'(ctr_r);
            out_item.past_face      = 17'(ctr_r);
            out_item.word_index     = '0;
            out_item.bone_mask_word = '0;
            out_item.bone_count     = 9'(fcount);
            out_item.last_of_split  = 1'b1;
            if (last_r) begin
              emit_mask_nxt  = run_r;
              emit_start_nxt = start_r;
              emit_end_nxt   = ctr_r;
              emit_cnt_nxt   = run_cnt_r;
              run_nxt        = '0;
              run_cnt_nxt    = '0;
              start_nxt      = '0;
              ctr_nxt        = '0;
            end
          end
        end else if (over_merge) begin
          // close the open split, the face opens a new one
          emit_mask_nxt  = run_r;
          emit_start_nxt = start_r;
          emit_end_nxt   = ctr_r;
          emit_cnt_nxt   = run_cnt_r;
          run_nxt        = face_r;
          run_cnt_nxt    = fcount;
          start_nxt      = ctr_r;
          ctr_nxt        = ctr_inc;
          final_pend_nxt = last_r;
        end else begin
          for (int w = 0; w < BW; w++) begin
            run_nxt[w] = run_r[w] | face_r[w];
          end
          run_cnt_nxt = mcount;
          ctr_nxt     = ctr_inc;
          if (last_r) begin
            for (int w = 0; w < BW; w++) begin
              emit_mask_nxt[w] = run_r[w] | face_r[w];
            end
            emit_start_nxt = start_r;
            emit_end_nxt   = ctr_inc;
            emit_cnt_nxt   = mcount;
            run_nxt        = '0;
            run_cnt_nxt    = '0;
            start_nxt      = '0;
            ctr_nxt        = '0;
          end
        end
      end
      BK_EMIT: begin
        if (ld_ok) begin
          out_load                = 1'b1;
          out_item.status         = ST_SPLIT;
          out_item.first_face     = 16'(emit_start_r);
          out_item.past_face      = 17'(emit_end_r);
          out_item.word_index     = 2'(word_r);
          out_item.bone_mask_word = emit_mask_r[0];
          out_item.bone_count     = 9'(emit_cnt_r);
          out_item.last_of_split  = (word_r == WORD_LAST);
          emit_mask_nxt           = emit_mask_r >> 64;
          if (word_r == WORD_LAST) begin
            word_nxt = '0;
            if (final_pend_r) begin
              // mesh ends right after a split closed: report the new one too
              final_pend_nxt = 1'b0;
              emit_mask_nxt  = run_r;
              emit_start_nxt = start_r;
              emit_end_nxt   = ctr_r;
              emit_cnt_nxt   = run_cnt_r;
              run_nxt        = '0;
              run_cnt_nxt    = '0;
              start_nxt      = '0;
              ctr_nxt        = '0;
            end
          end else begin
            word_nxt = word_r + 1'b1;
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      run_r        <= '0;
      run_cnt_r    <= '0;
      start_r      <= '0;
      ctr_r        <= '0;
      word_r       <= '0;
      final_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_r        <= run_nxt;
      run_cnt_r    <= run_cnt_nxt;
      start_r      <= start_nxt;
      ctr_r        <= ctr_nxt;
      word_r       <= word_nxt;
      final_pend_r <= final_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    face_r       <= face_nxt;
    bad_r        <= bad_nxt;
    last_r       <= last_nxt;
    fcw_r        <= fcw_nxt;
    mcw_r        <= mcw_nxt;
    emit_mask_r  <= emit_mask_nxt;
    emit_start_r <= emit_start_nxt;
    emit_end_r   <= emit_end_nxt;
    emit_cnt_r   <= emit_cnt_nxt;
    if (out_load) begin
      out_r <= out_item;
    end
  end

endmodule

@@ hw/rtl/bone_limited_face_splitter_core.sv @@
// top level of the bone-limited face splitter
//
// in_*: one bone slot per request, last_of_face on the
// final slot and last_face with it on the mesh's last face. out_*: one
// request per result: a closed split is reported as one request per 64-bit
// word of its bone mask, a dropped face as a single error request. cfg_*: writes
// max_bones, unused_is_minus_one and dynamic_mesh; the user must do so while idle, the block does not check.
//
// the front takes one slot every cycle while the queue has room and
// gathers the face's bone mask; finished faces wait in a two-entry queue
// for the back. the back takes each face through fetch, per-word popcount
// and decide, then sends the result words of a split one after another.
// the queue lets the front take the slots of later faces while the back
// works on an earlier one.
// the output register holds a result while out_ready is low; the back then
// stops at its next result, the queue fills and in_ready falls.
// reset empties the queue, clears the open split and face counter and
// loads max_bones 256 with both unused modes off.
module bone_limited_face_splitter_core #(
  parameter int BONE_SPACE = bfs_pkg::BONE_SPACE_DEF,
  parameter int MAX_FACES  = bfs_pkg::MAX_FACES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bfs_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bfs_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [bfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bfs_pkg::*;

  localparam int QW = ((BONE_SPACE + 63) / 64) * 64 + 2;

  cfg_t          cfg_r, cfg_nxt;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_BONES:     cfg_nxt.max_bones           = cfg_wdata;
        CFG_UNUSED_MINUS1: cfg_nxt.unused_is_minus_one = cfg_wdata[0];
        CFG_DYNAMIC_MESH:  cfg_nxt.dynamic_mesh        = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_bones           <= MAX_BONES_RST;
      cfg_r.unused_is_minus_one <= 1'b0;
      cfg_r.dynamic_mesh        <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bfs_front #(
    .BONE_SPACE(BONE_SPACE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  bfs_queue #(
    .W(QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  bfs_back #(
    .BONE_SPACE(BONE_SPACE),
    .MAX_FACES (MAX_FACES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // a finished face never lands on a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("face pushed into full queue");

  // error results are single requests with an empty mask
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_SPLIT)) |->
      (out_data.last_of_split && (out_data.word_index == 2'd0) &&
       (out_data.bone_mask_word == 64'd0)))
    else $error("malformed error result");

  // a split report ends on its top mask word
  a_split_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_SPLIT) && out_data.last_of_split) |->
      (out_data.word_index == 2'(((BONE_SPACE + 63) / 64) - 1)))
    else $error("split report ended on wrong word");

  // nothing is pending at the output right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
